FILE: rtl/spq_pkg.sv
package spq_pkg;

   // Operation codes carried in req_opcode
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   // Result status codes carried in rsp_status
   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_FULL      = 2'd1,
      STS_EMPTY     = 2'd2,
      STS_NOT_FOUND = 2'd3
   } status_type;

   // Controller states
   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_EXEC = 1'b1
   } ctl_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;   // capture request beat
      logic exec;   // run the captured operation, load result register
   } spq_cmd_type;

   localparam int ValueWidth = 32;
   localparam int PrioWidth  = 16;
   localparam int OccWidth   = 4;

endpackage

FILE: rtl/spq_ctrl.sv
module spq_ctrl
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output spq_cmd_type cmd
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // state and response-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd.load     = 1'b0;
      cmd.exec     = 1'b0;
      req_ready    = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         CTL_IDLE: begin
            // no beat is taken while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            // execute only once the result register is free or draining
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.exec     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/spq_datapath.sv
module spq_datapath
   import spq_pkg::*;
#(
   parameter int DEPTH = 8
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  spq_cmd_type                  cmd,
   input  logic [1:0]                   req_opcode,
   input  logic signed [ValueWidth-1:0] req_value,
   input  logic [PrioWidth-1:0]         req_prio,
   output logic [1:0]                   rsp_status,
   output logic signed [ValueWidth-1:0] rsp_out_value,
   output logic [PrioWidth-1:0]         rsp_out_prio,
   output logic [OccWidth-1:0]          rsp_occupancy
);

   localparam int CW = $clog2(DEPTH + 1);

   // captured request
   op_type                  op_ff;
   logic signed [ValueWidth-1:0] val_ff;
   logic [PrioWidth-1:0]    pr_ff;

   // sorted entry store, head at index 0
   logic signed [ValueWidth-1:0] value_ff [DEPTH];
   logic signed [ValueWidth-1:0] value_in [DEPTH];
   logic [PrioWidth-1:0]    prio_ff  [DEPTH];
   logic [PrioWidth-1:0]    prio_in  [DEPTH];
   logic [CW-1:0]           fill_ff, fill_in;

   // result register
   status_type              status_ff, status_in;
   logic signed [ValueWidth-1:0] out_value_ff, out_value_in;
   logic [PrioWidth-1:0]    out_prio_ff, out_prio_in;
   logic [OccWidth-1:0]     occ_ff, occ_in;

   logic [DEPTH-1:0]        held;
   logic [DEPTH-1:0]        stay;
   logic [DEPTH-1:0]        match;
   logic                    full, empty, found;
   logic signed [ValueWidth-1:0] found_value;
   logic [PrioWidth-1:0]    found_prio;
   logic [CW+OccWidth-1:0]  fill_wide;

   // per-entry compares
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         held[i]  = CW'(i) < fill_ff;
         stay[i]  = held[i] && (prio_ff[i] <= pr_ff);
         match[i] = held[i] && (value_ff[i] == val_ff);
      end
      full  = fill_ff == CW'(DEPTH);
      empty = fill_ff == '0;
   end

   // first match counted from the head
   always_comb begin
      found       = 1'b0;
      found_value = '0;
      found_prio  = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match[i]) begin
            found       = 1'b1;
            found_value = value_ff[i];
            found_prio  = prio_ff[i];
         end
      end
   end

   // operation execute: next store, count and result
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         value_in[i] = value_ff[i];
         prio_in[i]  = prio_ff[i];
      end
      fill_in      = fill_ff;
      status_in    = STS_OK;
      out_value_in = '0;
      out_prio_in  = '0;
      case (op_ff)
         OP_INSERT: begin
            if (full) begin
               status_in = STS_FULL;
            end else begin
               // entries past the insert point move up one place
               for (int i = 0; i < DEPTH; i++) begin
                  if (!stay[i]) begin
                     if (i == 0) begin
                        value_in[i] = val_ff;
                        prio_in[i]  = pr_ff;
                     end else if (stay[i-1]) begin
                        value_in[i] = val_ff;
                        prio_in[i]  = pr_ff;
                     end else begin
                        value_in[i] = value_ff[i-1];
                        prio_in[i]  = prio_ff[i-1];
                     end
                  end
               end
               fill_in = fill_ff + 1'b1;
            end
         end
         OP_REMOVE: begin
            if (empty) begin
               status_in = STS_EMPTY;
            end else begin
               out_value_in = value_ff[0];
               out_prio_in  = prio_ff[0];
               for (int i = 0; i < DEPTH - 1; i++) begin
                  value_in[i] = value_ff[i+1];
                  prio_in[i]  = prio_ff[i+1];
               end
               fill_in = fill_ff - 1'b1;
            end
         end
         OP_SEARCH: begin
            if (found) begin
               out_value_in = found_value;
               out_prio_in  = found_prio;
            end else begin
               status_in = STS_NOT_FOUND;
            end
         end
         default: begin
            status_in = STS_OK;
         end
      endcase
      fill_wide = (CW + OccWidth)'(fill_in);
      occ_in    = fill_wide[OccWidth-1:0];
   end

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.exec) begin
         fill_ff <= fill_in;
      end
   end

   // request capture, store and result payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= op_type'(req_opcode);
         val_ff <= req_value;
         pr_ff  <= req_prio;
      end
      if (cmd.exec) begin
         for (int i = 0; i < DEPTH; i++) begin
            value_ff[i] <= value_in[i];
            prio_ff[i]  <= prio_in[i];
         end
         status_ff    <= status_in;
         out_value_ff <= out_value_in;
         out_prio_ff  <= out_prio_in;
         occ_ff       <= occ_in;
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_out_value = out_value_ff;
   assign rsp_out_prio  = out_prio_ff;
   assign rsp_occupancy = occ_ff;

endmodule

FILE: rtl/stable_priority_queue.sv
// Stable priority queue: a sorted list of up to DEPTH entries, lowest
// priority number at the head, equal priorities leaving in arrival order.
// Request channel (req_valid/req_ready): req_opcode selects insert, remove
// head or search by value; req_value and req_prio carry the operands.
// Response channel (rsp_valid/rsp_ready): one beat per request with
// rsp_status, rsp_out_value, rsp_out_prio and rsp_occupancy (the entry
// count after the operation, low four bits).
// A request accepted from the request channel is captured in the request
// register, executed in the single execute step with parallel per-entry
// compares, and its result is registered in the response register. No new
// request is taken until the execute step of the last one is done.
// A new request is taken while a response is still waiting; it then holds
// in the execute step until the response register is taken or drains.
// A stalled receiver therefore stops the queue after at most one more
// request. Reset empties the queue and drops any pending response; entry
// storage is not cleared.
module stable_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH = 8
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_opcode,
   input  logic signed [ValueWidth-1:0] req_value,
   input  logic [PrioWidth-1:0]         req_prio,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic signed [ValueWidth-1:0] rsp_out_value,
   output logic [PrioWidth-1:0]         rsp_out_prio,
   output logic [OccWidth-1:0]          rsp_occupancy
);

   spq_cmd_type cmd;

   // handshake controller
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // entry store and operation datapath
   spq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_opcode    (req_opcode),
      .req_value     (req_value),
      .req_prio      (req_prio),
      .rsp_status    (rsp_status),
      .rsp_out_value (rsp_out_value),
      .rsp_out_prio  (rsp_out_prio),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule

FILE: test/tb_top.sv
module tb_top;
   import spq_pkg::*;

   localparam int DEPTH      = 8;
   localparam int CLK_PERIOD = 12;
   localparam logic signed [ValueWidth-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [ValueWidth-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

   // one response beat as the queue should report it
   typedef struct {
      status_type                   status;
      logic signed [ValueWidth-1:0] value;
      logic [PrioWidth-1:0]         prio;
      logic [OccWidth-1:0]          occupancy;
   } queue_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [1:0]                   req_opcode = OP_NOP;
   logic signed [ValueWidth-1:0] req_value = '0;
   logic [PrioWidth-1:0]         req_prio = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [1:0]                   rsp_status;
   logic signed [ValueWidth-1:0] rsp_out_value;
   logic [PrioWidth-1:0]         rsp_out_prio;
   logic [OccWidth-1:0]          rsp_occupancy;

   logic             no_idle = 1'b0;
   int               errors = 0;
   queue_result_type expected_results[$];

   // shadow copy of the sorted queue, head at index 0
   logic signed [ValueWidth-1:0] shadow_value [DEPTH];
   logic [PrioWidth-1:0]         shadow_prio [DEPTH];
   int                           held = 0;

   stable_priority_queue #(.DEPTH(DEPTH)) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_value     (req_value),
      .req_prio      (req_prio),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_out_value (rsp_out_value),
      .rsp_out_prio  (rsp_out_prio),
      .rsp_occupancy (rsp_occupancy)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // apply one operation to the shadow queue and return the expected beat
   function automatic queue_result_type predict_queue_op(op_type op,
                                                         logic signed [ValueWidth-1:0] v,
                                                         logic [PrioWidth-1:0] p);
      queue_result_type r;
      int               pos;
      r.status = STS_OK;
      r.value  = '0;
      r.prio   = '0;
      case (op)
         OP_INSERT: begin
            if (held >= DEPTH) begin
               r.status = STS_FULL;
            end else begin
               // land behind every entry of equal or better priority
               pos = 0;
               while (pos < held && shadow_prio[pos] <= p) pos++;
               for (int i = held; i > pos; i--) begin
                  shadow_value[i] = shadow_value[i-1];
                  shadow_prio[i]  = shadow_prio[i-1];
               end
               shadow_value[pos] = v;
               shadow_prio[pos]  = p;
               held++;
            end
         end
         OP_REMOVE: begin
            if (held == 0) begin
               r.status = STS_EMPTY;
            end else begin
               r.value = shadow_value[0];
               r.prio  = shadow_prio[0];
               for (int i = 1; i < held; i++) begin
                  shadow_value[i-1] = shadow_value[i];
                  shadow_prio[i-1]  = shadow_prio[i];
               end
               held--;
            end
         end
         OP_SEARCH: begin
            // first match counted from the head
            r.status = STS_NOT_FOUND;
            for (int i = 0; i < held; i++) begin
               if (shadow_value[i] == v) begin
                  r.status = STS_OK;
                  r.value  = shadow_value[i];
                  r.prio   = shadow_prio[i];
                  break;
               end
            end
         end
         OP_NOP: begin
         end
         default: begin
         end
      endcase
      r.occupancy = held[OccWidth-1:0];
      return r;
   endfunction

   // one request beat; valid stays high on return so back-to-back beats never dip
   task automatic send_op(op_type op, logic signed [ValueWidth-1:0] v,
                          logic [PrioWidth-1:0] p);
      while (!no_idle && $urandom_range(0, 99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_value  <= v;
      req_prio   <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_results.push_back(predict_queue_op(op, v, p));
   endtask

   function automatic logic signed [ValueWidth-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5, 6:    return $signed($urandom_range(0, 7)) - 4;
         7:          return VALUE_MIN;
         8:          return VALUE_MAX;
         default:    return '0;
      endcase
   endfunction

   // small priority pool makes ties common
   function automatic logic [PrioWidth-1:0] pick_prio();
      case ($urandom_range(0, 9))
         0, 1, 2, 3:    return PrioWidth'($urandom);
         4, 5, 6, 7:    return PrioWidth'($urandom_range(0, 3));
         8:             return '0;
         default:       return '1;
      endcase
   endfunction

   task automatic random_op(bit filling);
      int                           pick;
      logic signed [ValueWidth-1:0] v;
      op_type                       op;
      pick = $urandom_range(0, 99);
      v    = pick_value();
      if (pick < (filling ? 50 : 25)) begin
         op = OP_INSERT;
      end else if (pick < (filling ? 70 : 65)) begin
         op = OP_REMOVE;
      end else if (pick < 95) begin
         op = OP_SEARCH;
         // mostly look for something that is actually held
         if (held > 0 && $urandom_range(0, 9) < 6)
            v = shadow_value[$urandom_range(0, held - 1)];
      end else begin
         op = OP_NOP;
      end
      send_op(op, v, pick_prio());
   endtask

   // underflow, miss and no-op on an empty queue
   task automatic test_empty_queue();
      send_op(OP_REMOVE, '0, '0);
      send_op(OP_SEARCH, '0, '0);
      send_op(OP_NOP, -1, '1);
   endtask

   // extreme values and priorities, tie at priority zero
   task automatic test_extremes();
      send_op(OP_INSERT, VALUE_MIN, '1);
      send_op(OP_INSERT, VALUE_MAX, '0);
      send_op(OP_INSERT, -1, '0);
      send_op(OP_SEARCH, VALUE_MIN, '0);
      send_op(OP_REMOVE, '0, '0);
   endtask

   // fill to the top, overflow, duplicate search, then drain past empty
   task automatic test_fill_overflow_and_ties();
      send_op(OP_INSERT, 7, 16'd3);
      send_op(OP_INSERT, 7, 16'd1);
      send_op(OP_INSERT, 42, 16'd3);
      send_op(OP_INSERT, 0, 16'h8000);
      send_op(OP_INSERT, 5, 16'd1);
      send_op(OP_INSERT, 9, 16'd0);
      send_op(OP_INSERT, 11, 16'd0);
      send_op(OP_SEARCH, 7, '0);
      send_op(OP_NOP, '0, '0);
      repeat (DEPTH + 1) send_op(OP_REMOVE, '0, '0);
   endtask

   // randomly chosen fill and drain phases with idling on both sides
   task automatic test_random_mix();
      bit filling;
      filling = 1'b1;
      for (int n = 0; n < 800; n++) begin
         if (n % 30 == 29) filling = 1'($urandom_range(0, 1));
         random_op(filling);
      end
   endtask

   // back-to-back beats, receiver always ready
   task automatic test_burst_no_idle();
      no_idle = 1'b1;
      for (int n = 0; n < 250; n++) random_op((n / 25) % 2 == 0);
      no_idle = 1'b0;
   endtask

   // response checker and receiver stall pattern
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: response beat with none expected: status %0d value %0d prio %0d",
                     $time, rsp_status, rsp_out_value, rsp_out_prio);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               errors++;
            end
            if (rsp_out_value !== want.value) begin
               $display("%0t: out_value expected %0d actual %0d",
                        $time, want.value, rsp_out_value);
               errors++;
            end
            if (rsp_out_prio !== want.prio) begin
               $display("%0t: out_prio expected %0d actual %0d",
                        $time, want.prio, rsp_out_prio);
               errors++;
            end
            if (rsp_occupancy !== want.occupancy) begin
               $display("%0t: occupancy expected %0d actual %0d",
                        $time, want.occupancy, rsp_occupancy);
               errors++;
            end
         end
      end
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= 21);
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_empty_queue();
      test_extremes();
      test_fill_overflow_and_ties();
      test_random_mix();
      test_burst_no_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      // catch any stray beat after the last one
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // hang guard
   initial begin
      #(CLK_PERIOD * 300000);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
